@@ design/min_lcm_pair_search_defines.svh @@
// Assertion macros used by the top-level design file.
`ifndef MIN_LCM_PAIR_SEARCH_DEFINES_SVH
`define MIN_LCM_PAIR_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define MLPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define MLPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mlps_pkg.sv @@
package mlps_pkg;

  localparam int VAL_W     = 13;
  localparam int LCM_W     = 25;
  localparam int ADDR_W    = 13;
  localparam int M_W       = ADDR_W + 1;
  localparam int VALUE_MAX = 4096;
  localparam int MAX_ITEMS = 4096;
  localparam int MEM_DEPTH = VALUE_MAX + 1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] first_index;
    logic [VAL_W-1:0] second_index;
    logic [LCM_W-1:0] least_lcm;
    logic             found;
  } out_t;

  typedef struct packed {
    logic [1:0]       cnt;
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] second;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

endpackage

@@ design/min_lcm_pair_search.sv @@
// Channel  | Ports                    | Transaction
// input    | start, busy, in_data     | start high while busy is low
// result   | out_valid, out_data      | one-cycle strobe on out_valid
//
// Loading takes one item a cycle; the memory read-modify-write is forwarded between
// consecutive items of the same value.
// After the last item: a drain state, then the sieve, which reads the memory at each multiple
// (states RD and EV) and runs the LCM unit on each candidate pair, then the result.
// After each result and after reset a clearing pass walks the whole memory
// while busy stays high. Results cannot be stalled.
`include "min_lcm_pair_search_defines.svh"

module min_lcm_pair_search #(
  parameter int VALUE_MAX = mlps_pkg::VALUE_MAX,
  parameter int MAX_ITEMS = mlps_pkg::MAX_ITEMS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  mlps_pkg::in_t   in_data,
  output logic            out_valid,
  output mlps_pkg::out_t  out_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EV    = 3'd4;
  localparam logic [2:0] S_LCM   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam int VW = mlps_pkg::VAL_W;
  localparam int MW = mlps_pkg::M_W;

  logic [2:0]                  state_r;
  logic [VW-1:0]               count_r, largest_r, g_r, a_r, b_r, pa_r, pb_r;
  logic [VW-1:0]               best_pa_r, best_pb_r, ld_addr_r, ld_pos_r;
  logic [mlps_pkg::ADDR_W-1:0] clr_r;
  logic [MW-1:0]               m_r, m_step, g_inc;
  logic                        taken_r, ld_v_r, fwd_hit_r, lcm_go_r, out_valid_r;
  logic [mlps_pkg::LCM_W-1:0]  best_lcm_r, lcm_val;
  logic                        lcm_done, accept, item_ok, end_g, last_g, searching;
  mlps_pkg::entry_t            rd_data, src, upd, fwd_data_r;
  mlps_pkg::mem_wr_t           wr;
  mlps_pkg::out_t              out_data_r;
  logic [mlps_pkg::ADDR_W-1:0] rd_addr;

  assign busy      = (state_r != S_LOAD);
  assign accept    = start && !busy;
  assign item_ok   = (in_data.value != '0) && (in_data.value <= VW'(VALUE_MAX))
                     && (count_r < VW'(MAX_ITEMS));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign searching = (state_r == S_RD) || (state_r == S_EV) || (state_r == S_LCM);

  assign m_step = m_r + {1'b0, g_r};
  assign g_inc  = {1'b0, g_r} + MW'(1);
  assign end_g  = m_step > {1'b0, largest_r};
  assign last_g = g_inc > {1'b0, largest_r};

  // The entry of the previous item is still being written when the next item's read
  // is issued, so a matching value takes the freshly updated entry instead.
  always_comb begin
    src = fwd_hit_r ? fwd_data_r : rd_data;
    upd = src;
    if (src.cnt == 2'd0) begin
      upd.cnt   = 2'd1;
      upd.first = ld_pos_r;
    end else if (src.cnt == 2'd1) begin
      upd.cnt    = 2'd2;
      upd.second = ld_pos_r;
    end
  end

  always_comb begin
    if (state_r == S_CLEAR) begin
      wr.en   = 1'b1;
      wr.addr = clr_r;
      wr.data = '0;
    end else begin
      wr.en   = ld_v_r;
      wr.addr = ld_addr_r;
      wr.data = upd;
    end
    rd_addr = (state_r == S_LOAD) ? in_data.value : m_r[mlps_pkg::ADDR_W-1:0];
  end

  mlps_mem #(
    .DEPTH (VALUE_MAX + 1)
  ) u_mem (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  mlps_lcm u_lcm (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (lcm_go_r),
    .a      (a_r),
    .b      (b_r),
    .done_r (lcm_done),
    .lcm    (lcm_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ld_v_r      <= 1'b0;
      fwd_hit_r   <= 1'b0;
      lcm_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      largest_r   <= '0;
    end else begin
      out_valid_r <= 1'b0;
      lcm_go_r    <= 1'b0;
      ld_v_r      <= accept && item_ok;
      fwd_hit_r   <= ld_v_r && (ld_addr_r == in_data.value);
      fwd_data_r  <= upd;
      if (accept) begin
        ld_addr_r <= in_data.value;
        ld_pos_r  <= count_r + VW'(1);
        if (item_ok) begin
          count_r <= count_r + VW'(1);
          if (in_data.value > largest_r) begin
            largest_r <= in_data.value;
          end
        end
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + mlps_pkg::ADDR_W'(1);
          if (clr_r == mlps_pkg::ADDR_W'(VALUE_MAX)) begin
            state_r    <= S_LOAD;
            count_r    <= '0;
            largest_r  <= '0;
            best_lcm_r <= '1;
            best_pa_r  <= '0;
            best_pb_r  <= '0;
          end
        end
        S_LOAD: begin
          if (accept && in_data.last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (count_r >= VW'(2)) begin
            g_r     <= VW'(1);
            m_r     <= MW'(1);
            taken_r <= 1'b0;
            state_r <= S_RD;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_RD: state_r <= S_EV;
        S_EV: begin
          if (rd_data.cnt != 2'd0 && (taken_r || rd_data.cnt == 2'd2)) begin
            // Second occurrence found: either a repeat of this value or a new multiple.
            if (taken_r) begin
              b_r  <= m_r[VW-1:0];
              pb_r <= rd_data.first;
            end else begin
              a_r  <= m_r[VW-1:0];
              pa_r <= rd_data.first;
              b_r  <= m_r[VW-1:0];
              pb_r <= rd_data.second;
            end
            lcm_go_r <= 1'b1;
            state_r  <= S_LCM;
          end else begin
            if (rd_data.cnt != 2'd0) begin
              a_r     <= m_r[VW-1:0];
              pa_r    <= rd_data.first;
              taken_r <= 1'b1;
            end
            if (!end_g) begin
              m_r     <= m_step;
              state_r <= S_RD;
            end else if (last_g) begin
              state_r <= S_OUT;
            end else begin
              g_r     <= g_inc[VW-1:0];
              m_r     <= g_inc;
              taken_r <= 1'b0;
              state_r <= S_RD;
            end
          end
        end
        S_LCM: begin
          if (lcm_done) begin
            if (lcm_val < best_lcm_r) begin
              best_lcm_r <= lcm_val;
              best_pa_r  <= pa_r;
              best_pb_r  <= pb_r;
            end
            if (last_g) begin
              state_r <= S_OUT;
            end else begin
              g_r     <= g_inc[VW-1:0];
              m_r     <= g_inc;
              taken_r <= 1'b0;
              state_r <= S_RD;
            end
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          if (count_r >= VW'(2)) begin
            out_data_r.found        <= 1'b1;
            out_data_r.least_lcm    <= best_lcm_r;
            out_data_r.first_index  <= (best_pa_r < best_pb_r) ? best_pa_r : best_pb_r;
            out_data_r.second_index <= (best_pa_r < best_pb_r) ? best_pb_r : best_pa_r;
          end else begin
            out_data_r <= '0;
          end
          clr_r   <= '0;
          state_r <= S_CLEAR;
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  `MLPS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held for two cycles")
  `MLPS_ASSERT_NEXT(a_strobe_follows_out, state_r == S_OUT, out_valid, "result not emitted")
  `MLPS_ASSERT_NOW(a_no_write_in_search, searching, !wr.en, "memory written during the search")
  `MLPS_ASSERT_NOW(a_pair_ordered, out_valid && out_data.found, out_data.first_index < out_data.second_index, "result positions out of order")

endmodule

@@ design/mlps_mem.sv @@
module mlps_mem #(
  parameter int DEPTH = mlps_pkg::MEM_DEPTH
) (
  input  logic                           clk,
  input  mlps_pkg::mem_wr_t              wr,
  input  logic [mlps_pkg::ADDR_W-1:0]    rd_addr,
  output mlps_pkg::entry_t               rd_data_r
);

  mlps_pkg::entry_t mem_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

@@ design/mlps_lcm.sv @@
module mlps_lcm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [mlps_pkg::VAL_W-1:0]  a,
  input  logic [mlps_pkg::VAL_W-1:0]  b,
  output logic                        done_r,
  output logic [mlps_pkg::LCM_W-1:0]  lcm
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_GCD  = 2'd1;
  localparam logic [1:0] L_DIV  = 2'd2;
  localparam logic [1:0] L_MUL  = 2'd3;

  logic [1:0]                    st_r;
  logic [mlps_pkg::VAL_W-1:0]    u_r, v_r, a_r, b_r, gcd_r, q_r, rem_r, a_sh_r;
  logic [3:0]                    k_r, bit_r;
  logic [2*mlps_pkg::VAL_W-1:0]  prod_r;
  logic [mlps_pkg::VAL_W:0]      trial;

  assign trial = {rem_r, a_sh_r[mlps_pkg::VAL_W-1]};
  assign lcm   = prod_r[mlps_pkg::LCM_W-1:0];

  // Binary GCD, then restoring division of a by the GCD, then one multiply by b.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        L_IDLE: begin
          if (go) begin
            u_r  <= a;
            v_r  <= b;
            a_r  <= a;
            b_r  <= b;
            k_r  <= '0;
            st_r <= L_GCD;
          end
        end
        L_GCD: begin
          if (u_r == '0 || v_r == '0) begin
            gcd_r  <= mlps_pkg::VAL_W'((u_r | v_r) << k_r);
            rem_r  <= '0;
            q_r    <= '0;
            a_sh_r <= a_r;
            bit_r  <= '0;
            st_r   <= L_DIV;
          end else if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1;
            v_r <= v_r >> 1;
            k_r <= k_r + 4'd1;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r >= v_r) begin
            u_r <= u_r - v_r;
          end else begin
            v_r <= v_r - u_r;
          end
        end
        L_DIV: begin
          if (trial >= {1'b0, gcd_r}) begin
            rem_r <= mlps_pkg::VAL_W'(trial - {1'b0, gcd_r});
            q_r   <= {q_r[mlps_pkg::VAL_W-2:0], 1'b1};
          end else begin
            rem_r <= trial[mlps_pkg::VAL_W-1:0];
            q_r   <= {q_r[mlps_pkg::VAL_W-2:0], 1'b0};
          end
          a_sh_r <= a_sh_r << 1;
          bit_r  <= bit_r + 4'd1;
          if (bit_r == 4'(mlps_pkg::VAL_W - 1)) begin
            st_r <= L_MUL;
          end
        end
        L_MUL: begin
          prod_r <= q_r * b_r;
          done_r <= 1'b1;
          st_r   <= L_IDLE;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 5000000;

  // Software picture of the search: loads values, then runs the divisor sieve on the last item.
  class pair_predictor;
    bit [1:0] seen [1:mlps_pkg::VALUE_MAX];
    int unsigned first_pos [1:mlps_pkg::VALUE_MAX];
    int unsigned second_pos [1:mlps_pkg::VALUE_MAX];
    int unsigned top_value;
    int unsigned loaded;
    mlps_pkg::out_t expected_answers[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      for (int v = 1; v <= mlps_pkg::VALUE_MAX; v++) seen[v] = 0;
      top_value = 0;
      loaded = 0;
    endfunction

    function longint unsigned gcd_of(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    function void note_item(mlps_pkg::in_t item);
      int unsigned v;
      mlps_pkg::out_t ans;
      longint unsigned best, l;
      int unsigned pick [2];
      int unsigned pos [2];
      int unsigned taken, bf, bs, t;
      v = item.value;
      if (v >= 1 && v <= mlps_pkg::VALUE_MAX && loaded < mlps_pkg::MAX_ITEMS) begin
        loaded++;
        if (seen[v] == 0) first_pos[v] = loaded;
        else if (seen[v] == 1) second_pos[v] = loaded;
        if (seen[v] < 2) seen[v]++;
        if (v > top_value) top_value = v;
      end
      if (!item.last) return;
      ans = '0;
      if (loaded >= 2) begin
        best = '1;
        bf = 0;
        bs = 0;
        for (int unsigned g = 1; g <= top_value; g++) begin
          taken = 0;
          for (int unsigned m = g; m <= top_value && taken < 2; m += g) begin
            if (seen[m] == 0) continue;
            pick[taken] = m;
            pos[taken] = first_pos[m];
            taken++;
            if (taken < 2 && seen[m] >= 2) begin
              pick[taken] = m;
              pos[taken] = second_pos[m];
              taken++;
            end
          end
          if (taken == 2) begin
            l = pick[0] / gcd_of(pick[0], pick[1]) * pick[1];
            if (l < best) begin
              best = l;
              bf = pos[0];
              bs = pos[1];
            end
          end
        end
        if (bf > bs) begin
          t = bf;
          bf = bs;
          bs = t;
        end
        ans.first_index = bf[mlps_pkg::VAL_W-1:0];
        ans.second_index = bs[mlps_pkg::VAL_W-1:0];
        ans.least_lcm = best[mlps_pkg::LCM_W-1:0];
        ans.found = 1'b1;
      end
      expected_answers = {expected_answers, ans};
      clear();
    endfunction

    function void check_answer(mlps_pkg::out_t got);
      mlps_pkg::out_t want;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
        return;
      end
      want = expected_answers.pop_front();
      if (got.first_index !== want.first_index || got.second_index !== want.second_index ||
          got.least_lcm !== want.least_lcm || got.found !== want.found) begin
        mismatches++;
        if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  mlps_pkg::in_t in_data;
  logic out_valid;
  mlps_pkg::out_t out_data;

  pair_predictor predictor;
  bit steady;
  int unsigned cycles;

  min_lcm_pair_search u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) predictor.check_answer(out_data);
  end

  // Start stays high from one transaction to the next unless the sender idles.
  task automatic send(input int unsigned value, input bit last);
    mlps_pkg::in_t item;
    item.value = mlps_pkg::VAL_W'(value);
    item.last = last;
    if (!steady && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    predictor.note_item(item);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (predictor.expected_answers.size() != 0) @(posedge clk);
  endtask

  // Values up to the given bound, with an occasional out-of-range value mixed in.
  task automatic send_set(input int unsigned len, input int unsigned vmax);
    int unsigned v;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 5)
        v = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(mlps_pkg::VALUE_MAX + 1, 8191);
      else
        v = $urandom_range(1, vmax);
      send(v, i == len - 1);
    end
  endtask

  initial begin
    predictor = new();
    cycles = 0;
    steady = 0;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty and single-item searches, extremes and ignored values.
    send(0, 1'b1);
    send(7, 1'b1);
    send(4096, 1'b0);
    send(4096, 1'b1);
    send(1, 1'b0);
    send(4096, 1'b1);
    send(8191, 1'b0);
    send(6, 1'b0);
    send(0, 1'b0);
    send(4, 1'b0);
    send(6, 1'b0);
    send(3, 1'b1);
    send(5, 1'b0);
    send(7, 1'b0);
    send(4097, 1'b1);
    send(12, 1'b0);
    send(18, 1'b0);
    send(8, 1'b0);
    send(5461, 1'b0);
    send(2730, 1'b1);

    // Wait until every expected result has come before carrying on.
    drain();

    // A long set sent back to back with no idling.
    steady = 1;
    send_set(300, 16);
    steady = 0;

    // Two sets with large values so the sieve walks far.
    send_set(30, mlps_pkg::VALUE_MAX);
    send(4096, 1'b0);
    send($urandom_range(1, mlps_pkg::VALUE_MAX), 1'b1);

    for (int unsigned n = 0; n < 750; ) begin
      int unsigned len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 20);
      send_set(len, $urandom_range(2, 64));
      n += len;
    end

    drain();
    repeat (5000) @(posedge clk);
    if (predictor.mismatches == 0 && predictor.expected_answers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/mlps_pkg.sv
design/mlps_mem.sv
design/mlps_lcm.sv
design/min_lcm_pair_search.sv
test/tb_top.sv
